[rtl/trial_division_prime_test_assert.svh]
// Assertion macros shared by the trial-division prime test modules.
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tdp_pkg.sv]
// Package with widths and shared types of the trial-division prime test.
package tdp_pkg;

  localparam int VALUE_WIDTH     = 32;
  localparam int CNT_WIDTH       = $clog2(VALUE_WIDTH);
  localparam int IN_TDATA_WIDTH  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_WIDTH = 8;

  // Status of the serial divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
    logic quot_lt_div;
  } tdp_div_status_t;

endpackage

[rtl/tdp_divider.sv]
// Radix-2 serial divider: one quotient bit per cycle from a shift register.
`include "trial_division_prime_test_assert.svh"

module tdp_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [tdp_pkg::VALUE_WIDTH-1:0]  dividend,
  input  logic [tdp_pkg::VALUE_WIDTH-1:0]  divisor_in,
  output tdp_pkg::tdp_div_status_t         status
);

  localparam int W = tdp_pkg::VALUE_WIDTH;

  logic                           busy;
  logic                           done;
  logic [tdp_pkg::CNT_WIDTH-1:0]  cnt;
  // Dividend bits leave at the top while quotient bits enter at the bottom.
  logic [W-1:0]                   shreg;
  logic [W-1:0]                   rem;
  logic [W-1:0]                   divisor;

  logic [W:0]   rem_shift;
  logic [W-1:0] diff;
  logic         ge;
  logic [W-1:0] rem_next;

  always_comb begin
    rem_shift = {rem, shreg[W-1]};
    // The remainder stays below the divisor, so the low bits hold the whole difference.
    diff      = rem_shift[W-1:0] - divisor;
    ge        = rem_shift >= {1'b0, divisor};
    rem_next  = ge ? diff : rem_shift[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= tdp_pkg::CNT_WIDTH'(W - 1);
        shreg   <= dividend;
        rem     <= '0;
        divisor <= divisor_in;
      end else if (busy) begin
        shreg <= {shreg[W-2:0], ge};
        rem   <= rem_next;
        cnt   <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    status.busy        = busy;
    status.done        = done;
    status.rem_zero    = (rem == '0);
    status.quot_lt_div = (shreg < divisor);
  end

  `TDP_ASSERT_SAME(a_start_idle, clk, rst, start, !busy, "divider started while busy")
  `TDP_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "divider done while still busy")
  `TDP_ASSERT_NEXT(a_last_bit, clk, rst, busy && !start && (cnt == '0), done && !busy,
                   "divider did not finish after its last bit")

endmodule

[rtl/trial_division_prime_test.sv]
// Top level of the trial-division prime test with its sequencer.
//
// One beat in, one beat out: s_tdata carries a value, m_tdata answers whether
// it is prime. Values below four and even values are settled in the screening
// step, which passes the verdict to the finish step that loads the output
// register. Odd values above three are divided by the odd numbers from 3 up in
// a serial divider that produces one quotient bit per cycle; each divisor
// takes VALUE_WIDTH quotient bits and then a check that starts the next
// division. The test stops at the first zero remainder or once the quotient
// falls below the divisor, and at worst tries about 2^(VALUE_WIDTH/2 - 1)
// divisors for a 32-bit prime. One item is worked on at a time; a new beat is
// taken while the previous result still waits in the output register, and a
// finished verdict waits in the last step until that register is free.
`include "trial_division_prime_test_assert.svh"

module trial_division_prime_test (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [tdp_pkg::IN_TDATA_WIDTH-1:0]   s_tdata,   // [31:0] value
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [tdp_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata    // [0] is_prime, rest zero
);

  localparam int W = tdp_pkg::VALUE_WIDTH;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCREEN = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t   state;
  logic [W-1:0] value;
  logic [W-1:0] divisor;
  logic         verdict;

  logic                      div_start;
  logic [W-1:0]              div_divisor;
  tdp_pkg::tdp_div_status_t  div_stat;

  logic small_prime;
  logic trivial_composite;
  logic bound_hit;

  always_comb begin
    small_prime       = (value == W'(2)) || (value == W'(3));
    trivial_composite = (value[W-1:1] == '0) || !value[0];
    // The loop ends once the divisor exceeds value / divisor.
    bound_hit         = div_stat.quot_lt_div;
    div_start         = 1'b0;
    div_divisor       = divisor + W'(2);
    case (state)
      ST_SCREEN: begin
        div_start   = !small_prime && !trivial_composite;
        div_divisor = W'(3);
      end
      ST_DIV: begin
        div_start = div_stat.done && !bound_hit && !div_stat.rem_zero;
      end
      default: ;
    endcase
  end

  tdp_divider u_divider (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .dividend   (value),
    .divisor_in (div_divisor),
    .status     (div_stat)
  );

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      // In the finish step the output register is reloaded instead.
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      if (div_start) begin
        divisor <= div_divisor;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            value <= s_tdata[W-1:0];
            state <= ST_SCREEN;
          end
        end
        ST_SCREEN: begin
          if (small_prime) begin
            verdict <= 1'b1;
            state   <= ST_FINISH;
          end else if (trivial_composite) begin
            verdict <= 1'b0;
            state   <= ST_FINISH;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            if (bound_hit) begin
              verdict <= 1'b1;
              state   <= ST_FINISH;
            end else if (div_stat.rem_zero) begin
              verdict <= 1'b0;
              state   <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(tdp_pkg::OUT_TDATA_WIDTH - 1){1'b0}}, verdict};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `TDP_ASSERT_SAME(a_div_active, clk, rst, state == ST_DIV,
                   div_stat.busy || div_stat.done, "divider idle during trial division")
  `TDP_ASSERT_SAME(a_divisor_odd, clk, rst, state == ST_DIV,
                   divisor[0] && (divisor >= W'(3)), "trial divisor not odd or below three")
  `TDP_ASSERT_SAME(a_result_source, clk, rst, $rose(m_tvalid),
                   $past(state == ST_FINISH), "result appeared outside finish step")

endmodule
